// ===== sv/bwi_pkg.sv =====
// Shared types and constants for the Bezier waypoint interpolator.
// No dependencies; every other file but bwi_div imports this package.
package bwi_pkg;

  localparam int POS_W  = 24;
  localparam int HDG_W  = 16;
  localparam int IDX_W  = 6;
  localparam int CD_W   = 16;
  localparam int Q14_W  = 16;
  localparam int PH_W   = 18;

  // sine pipeline depth and divider quotient bits
  localparam int SIN_LAT = 5;
  localparam int Q_W     = 26;
  localparam int DIV_LAT = Q_W + 2;

  // quarter-wave polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [16:0] SIN_C = 17'd4640;

  // configuration register indexes
  localparam logic REG_CTRL_DIST = 1'b0;
  localparam logic REG_INTERVALS = 1'b1;

  localparam logic [CD_W-1:0]  CTRL_DIST_RST = 16'd230;
  localparam logic [IDX_W-1:0] INTERVALS_RST = 6'd63;

  typedef struct packed {
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic        [HDG_W-1:0] h0;
    logic signed [POS_W-1:0] ex;
    logic signed [POS_W-1:0] ey;
    logic        [HDG_W-1:0] h1;
    logic        [IDX_W-1:0] idx;
    logic        [IDX_W-1:0] n;
    logic                    last;
  } bwi_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [Q14_W-1:0] qz;
    logic signed [Q14_W-1:0] qw;
    logic        [IDX_W-1:0] idx;
    logic                    last;
  } bwi_result_t;

endpackage

// ===== sv/bezier_waypoint_interpolator.sv =====
// One request is a path segment; the block returns N+1 cubic Bezier points with yaw
// quaternions, one point per cycle when the output is taken, so a segment holds
// N+1 points (2 to 64), and when the next request is waiting its first point follows
// the last one with no gap. The point sequencer sets that rate; the datapath behind
// it is a 44-stage pipeline (sine units, a one-bit-per-stage divider). A skid stage
// on the output holds one result, so the pipeline keeps moving through an output
// stall until the skid fills.
module bezier_waypoint_interpolator #(
  parameter int MAX_INTERVALS = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_heading, end_x, end_y, end_heading
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y, quat_z, quat_w, point_index, 2 bits zero
  output logic [87:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import bwi_pkg::*;

  logic [CD_W-1:0]  ctrl_dist;
  logic [IDX_W-1:0] intervals;
  logic [IDX_W-1:0] n_clamp;

  logic             busy;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] n_cur;
  bwi_item_t        seg;
  bwi_item_t        item;
  logic             seq_last;
  logic             adv;
  logic             accept;

  logic             p_valid;
  bwi_result_t      p_res;
  logic             o_valid, k_valid;
  bwi_result_t      o_res, k_res;

  always_comb begin
    if (intervals == '0) begin
      n_clamp = IDX_W'(1);
    end else if (intervals > IDX_W'(MAX_INTERVALS)) begin
      n_clamp = IDX_W'(MAX_INTERVALS);
    end else begin
      n_clamp = intervals;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_dist <= CTRL_DIST_RST;
      intervals <= INTERVALS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CTRL_DIST: ctrl_dist <= cfg_data;
        REG_INTERVALS: intervals <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !k_valid;
  assign seq_last = (cnt == n_cur);
  assign s_tready = adv && (!busy || seq_last);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    item      = seg;
    item.idx  = cnt;
    item.n    = n_cur;
    item.last = seq_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (adv && busy) begin
      if (seq_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg.sx <= s_tdata[23:0];
      seg.sy <= s_tdata[47:24];
      seg.h0 <= s_tdata[63:48];
      seg.ex <= s_tdata[87:64];
      seg.ey <= s_tdata[111:88];
      seg.h1 <= s_tdata[127:112];
      seg.idx  <= '0;
      seg.n    <= '0;
      seg.last <= 1'b0;
      n_cur  <= n_clamp;
    end
  end

  bwi_pnt u_pnt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(busy), .in_item(item),
    .ctrl_dist(ctrl_dist), .out_valid(p_valid), .out_res(p_res));

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (k_valid) begin
      if (m_tready) begin
        k_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (o_valid && !m_tready) begin
        k_valid <= 1'b1;
      end else begin
        o_valid <= 1'b1;
      end
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (k_valid) begin
      if (m_tready) begin
        o_res <= k_res;
      end
    end else if (p_valid) begin
      if (o_valid && !m_tready) begin
        k_res <= p_res;
      end else begin
        o_res <= p_res;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_res.last;
  assign m_tdata  = {2'b00, o_res.idx, o_res.qw, o_res.qz, o_res.py, o_res.px};

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    k_valid |-> o_valid) else $error("skid holds data with empty output register");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !k_valid) else $error("request taken while pipeline stalled");

  a_seq_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && cnt == '0)) else $error("sequencer did not start segment");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && !seq_last && !accept) |=> (cnt == $past(cnt) + 1'b1))
    else $error("point index skipped");

endmodule

// ===== sv/bwi_sin.sv =====
// Pipelined Q1.14 sine of an 18-bit phase (2^18 per turn), five register stages.
// Depends on bwi_pkg for the polynomial coefficients.
module bwi_sin (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bwi_pkg::PH_W-1:0]    phase,
  output logic signed [bwi_pkg::Q14_W-1:0] val
);
  import bwi_pkg::*;

  logic [16:0] z_in;
  logic [16:0] z_s1, z_s2, z_s3, z_s4;
  logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4;
  logic [16:0] z2_s2, z2_s3;
  logic [16:0] t1_s3;
  logic [16:0] t2_s4;
  logic [33:0] zz, m3, m4, m5;
  logic [16:0] yr;
  logic [17:0] yq;
  logic [14:0] ycap;

  // odd quadrants mirror the phase
  assign z_in = phase[16] ? (17'h10000 - {1'b0, phase[15:0]}) : {1'b0, phase[15:0]};

  assign zz = z_s1 * z_s1;
  assign m3 = z2_s2 * SIN_C;
  assign m4 = z2_s3 * t1_s3;
  assign m5 = z_s4 * t2_s4;

  always_comb begin
    yr = m5[32:16];
    yq = (18'(yr) + 18'd2) >> 2;
    ycap = (yq > 18'd16384) ? 15'd16384 : yq[14:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_s1    <= z_in;
      quad_s1 <= phase[17:16];
      z2_s2   <= zz[32:16];
      z_s2    <= z_s1;
      quad_s2 <= quad_s1;
      t1_s3   <= SIN_B - m3[32:16];
      z2_s3   <= z2_s2;
      z_s3    <= z_s2;
      quad_s3 <= quad_s2;
      t2_s4   <= SIN_A - m4[32:16];
      z_s4    <= z_s3;
      quad_s4 <= quad_s3;
      val     <= quad_s4[1] ? -$signed({1'b0, ycap}) : $signed({1'b0, ycap});
    end
  end

endmodule

// ===== sv/bwi_div.sv =====
// Pipelined signed floor divider by a positive divisor, one quotient bit per stage.
// Depends on nothing but its parameters.
module bwi_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 19,
  parameter int Q_W   = 26
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [Q_W:0]     quo
);
  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem   [0:Q_W];
  logic [DEN_W-1:0] dv    [0:Q_W];
  logic [Q_W-1:0]   qa    [0:Q_W];
  logic             ng    [0:Q_W];
  logic [RW-1:0]    trial [0:Q_W-1];
  logic [NUM_W-1:0] mag;
  logic signed [Q_W:0] qm;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign qm  = $signed({1'b0, qa[Q_W]});

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      trial[j] = RW'(dv[j]) << (Q_W - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(mag);
      dv[0]  <= den;
      qa[0]  <= '0;
      ng[0]  <= num[NUM_W-1];
      for (int j = 0; j < Q_W; j++) begin
        dv[j+1] <= dv[j];
        ng[j+1] <= ng[j];
        if (rem[j] >= trial[j]) begin
          rem[j+1] <= rem[j] - trial[j];
          qa[j+1]  <= qa[j] | (Q_W'(1) << (Q_W - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          qa[j+1]  <= qa[j];
        end
      end
      // negative with remainder rounds one further down: -q - 1 is ~q
      if (ng[Q_W]) begin
        quo <= (rem[Q_W] != '0) ? ~qm : -qm;
      end else begin
        quo <= qm;
      end
    end
  end

endmodule

// ===== sv/bwi_pnt.sv =====
// Per-point datapath: control points, Bezier sums, division, yaw phase and quaternion.
// Depends on bwi_pkg, bwi_sin and bwi_div.
module bwi_pnt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  bwi_pkg::bwi_item_t        in_item,
  input  logic [bwi_pkg::CD_W-1:0]  ctrl_dist,
  output logic                      out_valid,
  output bwi_pkg::bwi_result_t      out_res
);
  import bwi_pkg::*;

  localparam int TOT = SIN_LAT + 5 + DIV_LAT + 1 + SIN_LAT;

  typedef struct packed {
    logic [HDG_W-1:0] h0;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } tail_t;

  function automatic logic signed [17:0] offq8(input logic [CD_W-1:0] cd,
                                               input logic signed [Q14_W-1:0] f);
    logic signed [32:0] v;
    v = $signed({1'b0, cd}) * f;
    v = v + 33'sd8192;
    return v[31:14];
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [Q_W:0] v);
    if (v > $signed(27'sd8388607)) return 24'sh7FFFFF;
    if (v < -$signed(27'sd8388608)) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

  logic [TOT-1:0] vld;

  // front sines
  logic signed [Q14_W-1:0] cos0, sin0, cos1, sin1;
  bwi_item_t itm_d [0:SIN_LAT-1];

  bwi_sin u_cos0 (.clk(clk), .en(en), .phase({in_item.h0, 2'b00} + 18'h10000), .val(cos0));
  bwi_sin u_sin0 (.clk(clk), .en(en), .phase({in_item.h0, 2'b00}), .val(sin0));
  bwi_sin u_cos1 (.clk(clk), .en(en), .phase({in_item.h1, 2'b00} + 18'h10000), .val(cos1));
  bwi_sin u_sin1 (.clk(clk), .en(en), .phase({in_item.h1, 2'b00}), .val(sin1));

  // stage 6
  bwi_item_t s6_item;
  logic signed [17:0] s6_oc0, s6_os0, s6_oc1, s6_os1;
  logic [11:0] s6_u2, s6_i2, s6_n2;
  logic [IDX_W-1:0] s6_u, u_c;
  assign u_c = itm_d[SIN_LAT-1].n - itm_d[SIN_LAT-1].idx;

  // stage 7
  bwi_item_t s7_item;
  logic signed [24:0] s7_cx1, s7_cy1, s7_cx2, s7_cy2;
  logic [17:0] s7_k0, s7_k1, s7_k2, s7_k3, s7_den3;

  // stage 8
  bwi_item_t s8_item;
  logic signed [43:0] s8_px0, s8_px1, s8_px2, s8_px3;
  logic signed [43:0] s8_py0, s8_py1, s8_py2, s8_py3;
  logic [17:0] s8_den3;

  // stage 9
  bwi_item_t s9_item;
  logic signed [43:0] s9_sax, s9_sbx, s9_say, s9_sby;
  logic [17:0] s9_den3;

  // stage 10
  tag_t s10_tag;
  logic signed [47:0] s10_numx, s10_numy;
  logic [18:0] s10_den;
  logic signed [25:0] s10_ynum;
  logic [6:0] s10_yden;
  logic [HDG_W-1:0] dw;
  logic signed [16:0] yd;
  logic signed [25:0] yprod;

  always_comb begin
    dw = s9_item.h1 - s9_item.h0;
    // wrap into (-half turn, +half turn]
    yd = (dw[15] && (dw[14:0] != '0)) ? $signed({1'b1, dw}) : $signed({1'b0, dw});
    yprod = $signed({1'b0, s9_item.idx}) * yd;
  end

  // dividers
  logic signed [Q_W:0] qx, qy, qyaw;
  tag_t tg [0:DIV_LAT-1];

  bwi_div #(.NUM_W(48), .DEN_W(19), .Q_W(Q_W)) u_divx (
    .clk(clk), .en(en), .num(s10_numx), .den(s10_den), .quo(qx));
  bwi_div #(.NUM_W(48), .DEN_W(19), .Q_W(Q_W)) u_divy (
    .clk(clk), .en(en), .num(s10_numy), .den(s10_den), .quo(qy));
  bwi_div #(.NUM_W(26), .DEN_W(7), .Q_W(Q_W)) u_divw (
    .clk(clk), .en(en), .num(s10_ynum), .den(s10_yden), .quo(qyaw));

  // post-divide stage and quaternion sines
  tail_t s11_tail;
  logic [PH_W-1:0] s11_ph;
  tail_t tl [0:SIN_LAT-1];
  logic signed [Q14_W-1:0] qz, qw;

  bwi_sin u_qz (.clk(clk), .en(en), .phase(s11_ph), .val(qz));
  bwi_sin u_qw (.clk(clk), .en(en), .phase(s11_ph + 18'h10000), .val(qw));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_d[0] <= in_item;
      for (int j = 1; j < SIN_LAT; j++) begin
        itm_d[j] <= itm_d[j-1];
      end

      s6_item <= itm_d[SIN_LAT-1];
      s6_oc0  <= offq8(ctrl_dist, cos0);
      s6_os0  <= offq8(ctrl_dist, sin0);
      s6_oc1  <= offq8(ctrl_dist, cos1);
      s6_os1  <= offq8(ctrl_dist, sin1);
      s6_u    <= u_c;
      s6_u2   <= u_c * u_c;
      s6_i2   <= itm_d[SIN_LAT-1].idx * itm_d[SIN_LAT-1].idx;
      s6_n2   <= itm_d[SIN_LAT-1].n * itm_d[SIN_LAT-1].n;

      s7_item <= s6_item;
      s7_cx1  <= 25'(s6_item.sx) + 25'(s6_oc0);
      s7_cy1  <= 25'(s6_item.sy) + 25'(s6_os0);
      s7_cx2  <= 25'(s6_item.ex) - 25'(s6_oc1);
      s7_cy2  <= 25'(s6_item.ey) - 25'(s6_os1);
      s7_k0   <= s6_u2 * s6_u;
      s7_k1   <= 18'd3 * s6_u2 * s6_item.idx;
      s7_k2   <= 18'd3 * s6_i2 * s6_u;
      s7_k3   <= s6_i2 * s6_item.idx;
      s7_den3 <= s6_n2 * s6_item.n;

      s8_item <= s7_item;
      s8_den3 <= s7_den3;
      s8_px0  <= $signed({1'b0, s7_k0}) * s7_item.sx;
      s8_px1  <= $signed({1'b0, s7_k1}) * s7_cx1;
      s8_px2  <= $signed({1'b0, s7_k2}) * s7_cx2;
      s8_px3  <= $signed({1'b0, s7_k3}) * s7_item.ex;
      s8_py0  <= $signed({1'b0, s7_k0}) * s7_item.sy;
      s8_py1  <= $signed({1'b0, s7_k1}) * s7_cy1;
      s8_py2  <= $signed({1'b0, s7_k2}) * s7_cy2;
      s8_py3  <= $signed({1'b0, s7_k3}) * s7_item.ey;

      s9_item <= s8_item;
      s9_den3 <= s8_den3;
      s9_sax  <= s8_px0 + s8_px1;
      s9_sbx  <= s8_px2 + s8_px3;
      s9_say  <= s8_py0 + s8_py1;
      s9_sby  <= s8_py2 + s8_py3;

      // round half up: floor((2*sum + den) / (2*den))
      s10_tag  <= '{h0: s9_item.h0, idx: s9_item.idx, last: s9_item.last};
      s10_numx <= ((s9_sax + s9_sbx) <<< 1) + $signed({30'b0, s9_den3});
      s10_numy <= ((s9_say + s9_sby) <<< 1) + $signed({30'b0, s9_den3});
      s10_den  <= {s9_den3, 1'b0};
      s10_ynum <= (yprod <<< 2) + $signed({20'b0, s9_item.n});
      s10_yden <= {s9_item.n, 1'b0};

      tg[0] <= s10_tag;
      for (int j = 1; j < DIV_LAT; j++) begin
        tg[j] <= tg[j-1];
      end

      s11_tail <= '{px: sat24(qx), py: sat24(qy),
                    idx: tg[DIV_LAT-1].idx, last: tg[DIV_LAT-1].last};
      s11_ph   <= {1'b0, tg[DIV_LAT-1].h0, 1'b0} + qyaw[PH_W-1:0];

      tl[0] <= s11_tail;
      for (int j = 1; j < SIN_LAT; j++) begin
        tl[j] <= tl[j-1];
      end
    end
  end

  assign out_valid = vld[TOT-1];
  assign out_res = '{px: tl[SIN_LAT-1].px, py: tl[SIN_LAT-1].py, qz: qz, qw: qw,
                     idx: tl[SIN_LAT-1].idx, last: tl[SIN_LAT-1].last};

endmodule
